[hw/rtl/bqsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqsc_pkg
// Shared types and constants for the smoothed-coefficient DF1 biquad.
// ----------------------------------------------------------------------------
package bqsc_pkg;

   // Coefficient format: signed Q3.28 in 32 bits
   localparam int COEF_W   = 32;
   localparam int DIFF_W   = COEF_W + 1;
   localparam int NUM_COEF = 5;
   localparam int IDX_W    = 3;

   // Smoother gain: unsigned Q1.24, saturated to one
   localparam int KP_W     = 25;
   localparam int KP_SHIFT = 24;
   localparam logic [KP_W-1:0] KP_ONE = 25'h100_0000;
   localparam logic [KP_W-1:0] KP_RESET = 25'd1978700;

   // Operation codes
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
   localparam logic [OP_W-1:0] OP_SNAP   = 2'd2;

   // Register map
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_SMOOTHING_GAIN = 2'd0;

   // Sequencer
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_LAST = 4'(2 * NUM_COEF - 1);

   // Tag that travels with each product through the shared multiplier
   typedef struct packed {
      logic             valid;
      logic             smooth;
      logic [IDX_W-1:0] idx;
   } mul_tag_type;

endpackage

[hw/rtl/bqsc_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqsc_mul
// Shared signed multiplier with registered product and tag.
// ----------------------------------------------------------------------------
module bqsc_mul #(
   parameter int A_W = 33,
   parameter int B_W = 26
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic signed [A_W-1:0]     op_a,
   input  logic signed [B_W-1:0]     op_b,
   input  bqsc_pkg::mul_tag_type     tag_in,
   output logic signed [A_W+B_W-1:0] product,
   output bqsc_pkg::mul_tag_type     tag_out
);
   import bqsc_pkg::*;

   localparam int P_W = A_W + B_W;

   logic signed [P_W-1:0] prod_ff;
   logic signed [P_W-1:0] prod_in;
   mul_tag_type           tag_ff;

   assign prod_in = P_W'(op_a) * P_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   assign product = prod_ff;
   assign tag_out = tag_ff;

endmodule

[hw/rtl/biquad_df1_smoothed_coefs_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_df1_smoothed_coefs_core
// Direct form I biquad with one-pole smoothed Q3.28 coefficients.
// ----------------------------------------------------------------------------
// For a filter word, the five coefficient smoother products and the five tap
// products all pass through one registered multiplier, one product issued
// per cycle in the run state, followed by a drain state and a round/saturate
// (finish) state. The sequencer returns to idle as the result is registered;
// the round/saturate state stretches for as long as the previous result
// still waits on the output register. Load and snap words complete in the
// cycle they are accepted and return no result. The next word is taken as
// soon as the sequencer is back in idle, even while the last result still
// waits on the output register.
module biquad_df1_smoothed_coefs_core #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 28
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [bqsc_pkg::OP_W-1:0]             req_operation,
   input  logic [bqsc_pkg::IDX_W-1:0]            req_coef_index,
   input  logic signed [bqsc_pkg::COEF_W-1:0]    req_coef_target,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_in,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_filtered_sample,
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [bqsc_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [bqsc_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [bqsc_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import bqsc_pkg::*;

   localparam int MUL_A_W = DIFF_W;
   localparam int MUL_B_W = (SAMPLE_BITS > KP_W + 1) ? SAMPLE_BITS : KP_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int TERM_W  = COEF_W + SAMPLE_BITS;
   localparam int ACC_W   = TERM_W + 3;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_RUN    = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   localparam logic signed [ACC_W-1:0] ROUND_F =
      {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] SMAX =
      {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SMIN =
      {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [PROD_W-1:0] ROUND_KP =
      {{(PROD_W-KP_SHIFT){1'b0}}, 1'b1, {(KP_SHIFT-1){1'b0}}};

   // state
   logic [KP_W-1:0]               gain_ff;
   logic signed [COEF_W-1:0]      goal_ff [NUM_COEF];
   logic signed [COEF_W-1:0]      cur_ff  [NUM_COEF];
   logic signed [SAMPLE_BITS-1:0] x0_ff, x1_ff, x2_ff, y1_ff, y2_ff;
   logic [1:0]                    state_ff;
   logic [STEP_W-1:0]             step_ff;
   logic signed [ACC_W-1:0]       acc_ff;
   logic signed [COEF_W-1:0]      held_cur_ff;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;

   // combinational
   logic                          req_fire;
   logic                          csr_write;
   logic                          issue_smooth;
   logic [IDX_W-1:0]              issue_idx;
   logic signed [COEF_W-1:0]      coef_sel;
   logic signed [COEF_W-1:0]      goal_sel;
   logic signed [SAMPLE_BITS-1:0] tap_sel;
   logic [KP_W-1:0]               kp_eff;
   logic signed [MUL_A_W-1:0]     op_a;
   logic signed [MUL_B_W-1:0]     op_b;
   mul_tag_type                   tag_in;
   logic signed [PROD_W-1:0]      product;
   mul_tag_type                   tag_out;
   logic signed [PROD_W-1:0]      kp_step;
   logic signed [COEF_W-1:0]      cur_upd_in;
   logic signed [ACC_W-1:0]       acc_in;
   logic signed [ACC_W-1:0]       y_wide;
   logic signed [SAMPLE_BITS-1:0] y_in;
   logic                          out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_SMOOTHING_GAIN) ? CSR_DATA_W'(gain_ff) : '0;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_sample = rsp_sample_ff;
   assign out_free            = !rsp_valid_ff || rsp_ready;

   // Issue side: smoother products first, then the five taps
   assign issue_smooth = (step_ff < STEP_W'(NUM_COEF));
   assign issue_idx    = issue_smooth ? step_ff[IDX_W-1:0]
                                      : IDX_W'(step_ff - STEP_W'(NUM_COEF));
   assign coef_sel     = cur_ff[issue_idx];
   assign goal_sel     = goal_ff[issue_idx];
   assign kp_eff       = (gain_ff > KP_ONE) ? KP_ONE : gain_ff;

   always_comb begin
      case (issue_idx)
         3'd0:    tap_sel = x0_ff;
         3'd1:    tap_sel = x1_ff;
         3'd2:    tap_sel = x2_ff;
         3'd3:    tap_sel = y1_ff;
         3'd4:    tap_sel = y2_ff;
         default: tap_sel = '0;
      endcase
   end

   always_comb begin
      if (issue_smooth) begin
         op_a = MUL_A_W'(goal_sel) - MUL_A_W'(coef_sel);
         op_b = $signed(MUL_B_W'({1'b0, kp_eff}));
      end else begin
         op_a = MUL_A_W'(coef_sel);
         op_b = MUL_B_W'(tap_sel);
      end
      tag_in.valid  = (state_ff == S_RUN);
      tag_in.smooth = issue_smooth;
      tag_in.idx    = issue_idx;
   end

   bqsc_mul #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .op_a    (op_a),
      .op_b    (op_b),
      .tag_in  (tag_in),
      .product (product),
      .tag_out (tag_out)
   );

   // Retire side: coefficient glide step or accumulate a tap term
   assign kp_step    = (product + ROUND_KP) >>> KP_SHIFT;
   assign cur_upd_in = held_cur_ff + kp_step[COEF_W-1:0];
   assign acc_in     = acc_ff + ACC_W'($signed(product[TERM_W-1:0]));

   // Round halves up, then clamp to the sample range
   assign y_wide = (acc_ff + ROUND_F) >>> COEF_FRAC_BITS;
   always_comb begin
      if (y_wide > SMAX) begin
         y_in = SMAX[SAMPLE_BITS-1:0];
      end else if (y_wide < SMIN) begin
         y_in = SMIN[SAMPLE_BITS-1:0];
      end else begin
         y_in = y_wide[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= KP_RESET;
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         x0_ff        <= '0;
         x1_ff        <= '0;
         x2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
         acc_ff       <= '0;
         for (int k = 0; k < NUM_COEF; k++) begin
            goal_ff[k] <= '0;
            cur_ff[k]  <= '0;
         end
      end else begin
         if (csr_write && (csr_paddr == CSR_SMOOTHING_GAIN)) begin
            gain_ff <= csr_pwdata[KP_W-1:0];
         end

         // drop the word unless a new result is loaded in the same cycle
         if (rsp_valid_ff && rsp_ready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         if (tag_in.valid) begin
            held_cur_ff <= coef_sel;
         end

         if (tag_out.valid) begin
            if (tag_out.smooth) begin
               cur_ff[tag_out.idx] <= cur_upd_in;
            end else begin
               acc_ff <= acc_in;
            end
         end

         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  case (req_operation)
                     OP_FILTER: begin
                        x0_ff    <= req_sample_in;
                        acc_ff   <= '0;
                        step_ff  <= '0;
                        state_ff <= S_RUN;
                     end
                     OP_LOAD: begin
                        if (req_coef_index < IDX_W'(NUM_COEF)) begin
                           goal_ff[req_coef_index] <= req_coef_target;
                        end
                     end
                     OP_SNAP: begin
                        for (int k = 0; k < NUM_COEF; k++) begin
                           cur_ff[k] <= goal_ff[k];
                        end
                        x1_ff <= req_sample_in;
                        x2_ff <= req_sample_in;
                        y1_ff <= req_sample_in;
                        y2_ff <= req_sample_in;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_RUN: begin
               if (step_ff == STEP_LAST) begin
                  state_ff <= S_DRAIN;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               // hold until the output register is free
               if (out_free) begin
                  rsp_sample_ff <= y_in;
                  rsp_valid_ff  <= 1'b1;
                  x2_ff         <= x1_ff;
                  x1_ff         <= x0_ff;
                  y2_ff         <= y1_ff;
                  y1_ff         <= y_in;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
